// File: hw/rtl/tbf_pkg.sv
// tbf_pkg: shared types and constants of the tangent frame block
// holds transaction payload structs, datapath widths and the sequencer states
// no dependencies
`default_nettype none

package tbf_pkg;

    localparam int POS_W  = 32;
    localparam int TEX_W  = 20;
    localparam int EDGE_W = POS_W + 1;
    localparam int DLT_W  = TEX_W + 1;
    localparam int PROD_W = EDGE_W + DLT_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int DET_W  = 2 * DLT_W + 1;
    localparam int QUO_W  = 32;
    localparam int SCL_SH = 16;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    typedef struct packed {
        logic [1:0]              corner;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } t_in_item;

    typedef struct packed {
        logic signed [QUO_W-1:0] tangent_x;
        logic signed [QUO_W-1:0] tangent_y;
        logic signed [QUO_W-1:0] tangent_z;
        logic signed [QUO_W-1:0] bitangent_x;
        logic signed [QUO_W-1:0] bitangent_y;
        logic signed [QUO_W-1:0] bitangent_z;
        logic                    degenerate;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DET0,
        ST_DET1,
        ST_CHK,
        ST_NUM0,
        ST_NUM1,
        ST_DIV,
        ST_WAIT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/triangle_tangent_frame.sv
// triangle_tangent_frame: tangent and bitangent of a triangle from its UVs
// holds corner storage, the multiply-accumulate unit and the sequencer; uses tbf_pkg, tbf_div
// Corners arrive one transaction at a time. Corners 0 and 1 are stored
// and the block stays ready; corner 3 is dropped. Corner 2 starts the work
// and the block is busy after it: edge set-up, the UV determinant and its
// zero check, then six components each taking the NUM0 and NUM1
// multiply-accumulate states, a divider start and a wait on the 32-step
// restoring divide, and finally the load of the output register. The shared
// divider sets the rate. A zero determinant skips the divides and gives zero
// vectors with degenerate set. The result waits in an output register until
// taken; a result still waiting there holds the load cycle.
`default_nettype none

module triangle_tangent_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire tbf_pkg::t_in_item    i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output tbf_pkg::t_out_item        o_out_data
);
    import tbf_pkg::*;

    t_state r_state, n_state;

    logic signed [POS_W-1:0]  r_p0 [3];
    logic signed [POS_W-1:0]  r_p1 [3];
    logic signed [POS_W-1:0]  r_p2 [3];
    logic signed [TEX_W-1:0]  r_t0 [2];
    logic signed [TEX_W-1:0]  r_t1 [2];
    logic signed [TEX_W-1:0]  r_t2 [2];
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [DLT_W-1:0]  r_du1, r_dv1, r_du2, r_dv2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DET_W-1:0]  r_det;
    logic signed [QUO_W-1:0]  r_res [6];
    logic [2:0]               r_k;
    logic                     r_degen;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_accept;
    logic [1:0]               w_i;
    logic signed [EDGE_W-1:0] w_x;
    logic signed [DLT_W-1:0]  w_y;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_mac_en, w_clr, w_sub;
    logic                     w_div_start, w_div_done;
    logic signed [QUO_W-1:0]  w_quo;
    logic                     w_load;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_i        = (r_k < 3'd3) ? r_k[1:0] : 2'(r_k - 3'd3);

    // corner storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (i_in_data.corner)
                CORNER_0: begin
                    r_p0[0] <= i_in_data.pos_x;
                    r_p0[1] <= i_in_data.pos_y;
                    r_p0[2] <= i_in_data.pos_z;
                    r_t0[0] <= i_in_data.tex_u;
                    r_t0[1] <= i_in_data.tex_v;
                end
                CORNER_1: begin
                    r_p1[0] <= i_in_data.pos_x;
                    r_p1[1] <= i_in_data.pos_y;
                    r_p1[2] <= i_in_data.pos_z;
                    r_t1[0] <= i_in_data.tex_u;
                    r_t1[1] <= i_in_data.tex_v;
                end
                CORNER_2: begin
                    r_p2[0] <= i_in_data.pos_x;
                    r_p2[1] <= i_in_data.pos_y;
                    r_p2[2] <= i_in_data.pos_z;
                    r_t2[0] <= i_in_data.tex_u;
                    r_t2[1] <= i_in_data.tex_v;
                end
                default: begin
                end
            endcase
        end
    end

    // edges and uv deltas
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= $signed({r_p1[i][POS_W-1], r_p1[i]})
                         - $signed({r_p0[i][POS_W-1], r_p0[i]});
                r_e2[i] <= $signed({r_p2[i][POS_W-1], r_p2[i]})
                         - $signed({r_p0[i][POS_W-1], r_p0[i]});
            end
            r_du1 <= $signed({r_t1[0][TEX_W-1], r_t1[0]}) - $signed({r_t0[0][TEX_W-1], r_t0[0]});
            r_dv1 <= $signed({r_t1[1][TEX_W-1], r_t1[1]}) - $signed({r_t0[1][TEX_W-1], r_t0[1]});
            r_du2 <= $signed({r_t2[0][TEX_W-1], r_t2[0]}) - $signed({r_t0[0][TEX_W-1], r_t0[0]});
            r_dv2 <= $signed({r_t2[1][TEX_W-1], r_t2[1]}) - $signed({r_t0[1][TEX_W-1], r_t0[1]});
        end
    end

    // shared multiply-accumulate unit
    assign w_prod = w_x * w_y;

    always_ff @(posedge i_clk) begin
        if (w_mac_en) begin
            if (w_sub) begin
                r_acc <= (w_clr ? ACC_W'(0) : r_acc) - $signed({w_prod[PROD_W-1], w_prod});
            end else begin
                r_acc <= (w_clr ? ACC_W'(0) : r_acc) + $signed({w_prod[PROD_W-1], w_prod});
            end
        end
    end

    tbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_det   (r_det),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and operand selection
    always_comb begin
        n_state     = r_state;
        w_mac_en    = 1'b0;
        w_clr       = 1'b0;
        w_sub       = 1'b0;
        w_x         = r_e1[w_i];
        w_y         = r_dv2;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_data.corner == CORNER_2) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_DET0;
            end
            ST_DET0: begin
                w_mac_en = 1'b1;
                w_clr    = 1'b1;
                w_x      = EDGE_W'(r_du1);
                w_y      = r_dv2;
                n_state  = ST_DET1;
            end
            ST_DET1: begin
                w_mac_en = 1'b1;
                w_sub    = 1'b1;
                w_x      = EDGE_W'(r_du2);
                w_y      = r_dv1;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                n_state = (r_acc == '0) ? ST_OUT : ST_NUM0;
            end
            ST_NUM0: begin
                w_mac_en = 1'b1;
                w_clr    = 1'b1;
                if (r_k < 3'd3) begin
                    w_x = r_e1[w_i];
                    w_y = r_dv2;
                end else begin
                    w_x = r_e2[w_i];
                    w_y = r_du1;
                end
                n_state = ST_NUM1;
            end
            ST_NUM1: begin
                w_mac_en = 1'b1;
                w_sub    = 1'b1;
                if (r_k < 3'd3) begin
                    w_x = r_e2[w_i];
                    w_y = r_dv1;
                end else begin
                    w_x = r_e1[w_i];
                    w_y = r_du2;
                end
                n_state = ST_DIV;
            end
            ST_DIV: begin
                w_div_start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_k == 3'd5) ? ST_OUT : ST_NUM0;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // component counter, determinant and quotient collection
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_k <= '0;
        end else if (r_state == ST_WAIT && w_div_done) begin
            r_k <= r_k + 1'b1;
        end
        if (r_state == ST_CHK) begin
            r_det   <= r_acc[DET_W-1:0];
            r_degen <= (r_acc == '0);
            for (int i = 0; i < 6; i++) begin
                r_res[i] <= '0;
            end
        end else if (r_state == ST_WAIT && w_div_done) begin
            r_res[r_k] <= w_quo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.tangent_x   <= r_res[0];
            r_out.tangent_y   <= r_res[1];
            r_out.tangent_z   <= r_res[2];
            r_out.bitangent_x <= r_res[3];
            r_out.bitangent_y <= r_res[4];
            r_out.bitangent_z <= r_res[5];
            r_out.degenerate  <= r_degen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/tbf_div.sv
// tbf_div: radix-2 restoring divider, num * 2^16 / det, truncated and saturated
// one quotient bit per cycle; uses tbf_pkg
`default_nettype none

module tbf_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [tbf_pkg::ACC_W-1:0]     i_num,
    input  wire logic signed [tbf_pkg::DET_W-1:0]     i_det,
    output logic                                      o_done,
    output logic signed [tbf_pkg::QUO_W-1:0]          o_quo
);
    import tbf_pkg::*;

    localparam int REM_W = ACC_W + SCL_SH;
    localparam int DSH_W = DET_W + QUO_W - 1;
    localparam int CMP_W = DET_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic [ACC_W-1:0] w_a;
    logic [DET_W-1:0] w_d;
    logic [REM_W-1:0] r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic             r_sat;
    logic             w_ge;
    logic [QUO_W:0]   w_lim;
    logic [QUO_W:0]   w_mag;
    logic [QUO_W:0]   w_res;

    // operand magnitudes
    assign w_a  = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign w_d  = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
    assign w_ge = DSH_W'(r_rem) >= r_dsh;

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {w_a, {SCL_SH{1'b0}}};
            r_dsh <= {w_d, {(QUO_W-1){1'b0}}};
            r_quo <= '0;
            r_cnt <= CNT_W'(QUO_W - 1);
            r_neg <= i_num[ACC_W-1] ^ i_det[DET_W-1];
            r_sat <= CMP_W'({w_a, {SCL_SH{1'b0}}}) >= {w_d, {QUO_W{1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem        <= r_rem - r_dsh[REM_W-1:0];
                r_quo[r_cnt] <= 1'b1;
            end
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // saturate and apply sign
    always_comb begin
        w_lim = r_neg ? (QUO_W+1)'(1) << (QUO_W - 1)
                      : ((QUO_W+1)'(1) << (QUO_W - 1)) - 1'b1;
        if (r_sat || {1'b0, r_quo} > w_lim) begin
            w_mag = w_lim;
        end else begin
            w_mag = {1'b0, r_quo};
        end
        w_res = r_neg ? -w_mag : w_mag;
    end

    assign o_quo  = w_res[QUO_W-1:0];
    assign o_done = r_done;

endmodule

`default_nettype wire
